// File: rtl/mep_pkg.sv
// Shared types, constants and the color map of the Mandelbrot escape-time pixel.
// No dependencies; mep_ctrl, mep_dp and the top level import this package.
package mep_pkg;

  localparam int FRAC_BITS_DEF = 28;
  localparam int COORD_BITS    = 12;
  localparam int STEP_W        = 31;
  localparam int OFFSET_W      = 32;
  localparam int COUNT_W       = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 32;

  localparam logic signed [OFFSET_W-1:0] OFFSET_REAL_RST = -32'sd590558003;
  localparam logic signed [OFFSET_W-1:0] OFFSET_IMAG_RST = -32'sd301989888;
  localparam logic [STEP_W-1:0]          STEP_SIZE_RST   = 31'd838861;
  localparam logic [COUNT_W-1:0]         MAX_ITER_RST    = 16'd32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_OFFSET_REAL = 2'd0,
    CFG_OFFSET_IMAG = 2'd1,
    CFG_STEP_SIZE   = 2'd2,
    CFG_MAX_ITER    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_W-1:0] iteration_count;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } result_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_ADD,
    ST_ITER_MUL,
    ST_ITER_ADD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_pixel;
    logic map_mul;
    logic map_add;
    logic iter_mul;
    logic iter_upd;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic at_limit;
    logic outside;
    logic sum_escape;
  } stat_t;

  // Color of a count. The index (count*32 mod 65536) mod 1536 splits into a
  // ramp number {count[10:4] mod 3, count[3]} and a ramp position {count[2:0], 5'b0}.
  function automatic rgb_t rainbow(input logic [COUNT_W-1:0] count);
    logic [1:0] m;
    logic [2:0] seg;
    logic [7:0] v;
    rgb_t       c;
    m = 2'd0;
    for (int i = 10; i >= 4; i--) begin
      unique case ({m, count[i]})
        3'b000:  m = 2'd0;
        3'b001:  m = 2'd1;
        3'b010:  m = 2'd2;
        3'b011:  m = 2'd0;
        3'b100:  m = 2'd1;
        3'b101:  m = 2'd2;
        default: m = 2'd0;
      endcase
    end
    seg = {m, count[3]};
    v   = {count[2:0], 5'b00000};
    case (seg)
      3'd0: begin
        c = '{red: 8'd255, green: v, blue: 8'd0};
      end
      3'd1: begin
        c = '{red: 8'd255 - v, green: 8'd255, blue: 8'd0};
      end
      3'd2: begin
        c = '{red: 8'd0, green: 8'd255, blue: v};
      end
      3'd3: begin
        c = '{red: 8'd0, green: 8'd255 - v, blue: 8'd255};
      end
      3'd4: begin
        c = '{red: v, green: 8'd0, blue: 8'd255};
      end
      default: begin
        c = '{red: 8'd255, green: 8'd0, blue: 8'd255 - v};
      end
    endcase
    return c;
  endfunction

endpackage

// File: rtl/mep_ctrl.sv
// Sequencer of the escape-time pixel: mapping, iteration loop and result load.
// Depends on mep_pkg for the state, command and status types.
module mep_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mep_pkg::stat_t stat,
  output mep_pkg::cmd_t  cmd,
  output logic           busy
);
  import mep_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_pixel = 1'b1;
          state_next     = ST_MAP_MUL;
        end
      end
      ST_MAP_MUL: begin
        cmd.map_mul = 1'b1;
        state_next  = ST_MAP_ADD;
      end
      ST_MAP_ADD: begin
        cmd.map_add = 1'b1;
        state_next  = ST_ITER_MUL;
      end
      ST_ITER_MUL: begin
        if (stat.at_limit || stat.outside) begin
          state_next = ST_FINISH;
        end else begin
          cmd.iter_mul = 1'b1;
          state_next   = ST_ITER_ADD;
        end
      end
      ST_ITER_ADD: begin
        if (stat.sum_escape) begin
          state_next = ST_FINISH;
        end else begin
          cmd.iter_upd = 1'b1;
          state_next   = ST_ITER_MUL;
        end
      end
      ST_FINISH: begin
        cmd.load_result = 1'b1;
        state_next      = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/mep_dp.sv
// Datapath of the escape-time pixel: coordinate mapping, z iteration, color.
// Depends on mep_pkg; driven by the commands of mep_ctrl.
module mep_dp #(
  parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mep_pkg::cmd_t                        cmd,
  output mep_pkg::stat_t                       stat,
  input  mep_pkg::pixel_t                      pixel,
  input  logic signed [mep_pkg::OFFSET_W-1:0]  offset_real,
  input  logic signed [mep_pkg::OFFSET_W-1:0]  offset_imag,
  input  logic [mep_pkg::STEP_W-1:0]           step_size,
  input  logic [mep_pkg::COUNT_W-1:0]          max_iterations,
  output logic                                 done,
  output mep_pkg::result_t                     result
);
  import mep_pkg::*;

  localparam int PROD_W = COORD_BITS + STEP_W;
  localparam int C_W    = PROD_W + 2;
  localparam int MAG_W  = FRAC_BITS + 1;
  localparam int SQ_W   = FRAC_BITS + 2;
  localparam int Z_W    = ((C_W > FRAC_BITS + 4) ? C_W : FRAC_BITS + 4) + 1;

  logic [COORD_BITS-1:0] px, py;
  logic [PROD_W-1:0]     prod_x, prod_y;
  logic signed [C_W-1:0] cr, ci;
  logic signed [Z_W-1:0] zr, zi;
  logic [COUNT_W-1:0]    count;
  logic [SQ_W-1:0]       sq_r, sq_i, cross_mag;
  logic                  cross_neg;

  logic [Z_W-1:0]        abs_r, abs_i;
  logic [MAG_W-1:0]      mag_r, mag_i;
  logic [2*MAG_W-1:0]    full_rr, full_ii, full_ri;
  logic [SQ_W:0]         sum_sq;
  logic signed [Z_W-1:0] cross_s, zr_next, zi_next;

  // Escape test on the current z and the limit test on the count.
  assign abs_r = zr[Z_W-1] ? Z_W'(-zr) : Z_W'(zr);
  assign abs_i = zi[Z_W-1] ? Z_W'(-zi) : Z_W'(zi);
  assign mag_r = abs_r[MAG_W-1:0];
  assign mag_i = abs_i[MAG_W-1:0];

  assign stat.outside  = (|abs_r[Z_W-1:MAG_W]) || (|abs_i[Z_W-1:MAG_W]);
  assign stat.at_limit = count >= max_iterations;

  assign full_rr = (2*MAG_W)'(mag_r) * (2*MAG_W)'(mag_r);
  assign full_ii = (2*MAG_W)'(mag_i) * (2*MAG_W)'(mag_i);
  assign full_ri = (2*MAG_W)'(mag_r) * (2*MAG_W)'(mag_i);

  assign sum_sq          = {1'b0, sq_r} + {1'b0, sq_i};
  assign stat.sum_escape = sum_sq >= ((SQ_W+1)'(1) << (FRAC_BITS + 2));

  assign cross_s = cross_neg ? -$signed({{(Z_W-SQ_W){1'b0}}, cross_mag})
                             :  $signed({{(Z_W-SQ_W){1'b0}}, cross_mag});
  assign zr_next = $signed({{(Z_W-SQ_W){1'b0}}, sq_r}) - $signed({{(Z_W-SQ_W){1'b0}}, sq_i})
                 + $signed({{(Z_W-C_W){cr[C_W-1]}}, cr});
  assign zi_next = cross_s + cross_s + $signed({{(Z_W-C_W){ci[C_W-1]}}, ci});

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      px <= pixel.pixel_x;
      py <= pixel.pixel_y;
    end
    if (cmd.map_mul) begin
      prod_x <= PROD_W'(px) * PROD_W'(step_size);
      prod_y <= PROD_W'(py) * PROD_W'(step_size);
    end
    if (cmd.map_add) begin
      cr    <= $signed({2'b00, prod_x}) + $signed({{(C_W-OFFSET_W){offset_real[OFFSET_W-1]}},
                                                   offset_real});
      ci    <= $signed({2'b00, prod_y}) + $signed({{(C_W-OFFSET_W){offset_imag[OFFSET_W-1]}},
                                                   offset_imag});
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end
    if (cmd.iter_mul) begin
      sq_r      <= full_rr[2*MAG_W-1:FRAC_BITS];
      sq_i      <= full_ii[2*MAG_W-1:FRAC_BITS];
      cross_mag <= full_ri[2*MAG_W-1:FRAC_BITS];
      cross_neg <= zr[Z_W-1] ^ zi[Z_W-1];
    end
    if (cmd.iter_upd) begin
      zr    <= zr_next;
      zi    <= zi_next;
      count <= count + COUNT_W'(1);
    end
    if (cmd.load_result) begin
      result.iteration_count        <= count;
      {result.red, result.green, result.blue} <= rainbow(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.load_result;
    end
  end

endmodule

// File: rtl/mandelbrot_escape_pixel.sv
// Top level of the Mandelbrot escape-time pixel: configuration registers,
// sequencer and datapath. Depends on mep_pkg, mep_ctrl and mep_dp.
//
// Usage. A request is one pixel coordinate on pixel; it is taken at a rising
// edge where start is high and busy is low. The coordinate is mapped to
// c = pixel * step_size + offset, and z = z*z + c is iterated from zero until
// the iteration limit is reached or z leaves the radius-two circle.
// The result (iteration count and rainbow color) is registered on result and
// held; done flags it for exactly one cycle. The receiver cannot stall, so
// nothing waits on it. The sequencer maps the coordinate (multiply, then add),
// then loops: ITER_MUL drives the three squaring/cross multipliers, ITER_ADD
// the escape sum and the z update. The loop ends in ITER_MUL on the limit or
// the coordinate bound, in ITER_ADD on the |z|^2 test; FINISH loads the result.
// Only one pixel is in flight; busy drops in the cycle that shows done, so the
// next request can be taken in that same cycle.
// Configuration writes on the cfg channel are always accepted (cfg_ready is
// high) and must only be made while busy is low and no result is pending.
// Reset (synchronous, active high) returns the sequencer to idle, clears done
// and loads the default view: origin about (-2.2, -1.125), step about 1/320,
// iteration limit 32.
module mandelbrot_escape_pixel #(
  parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  mep_pkg::pixel_t                     pixel,
  output logic                                done,
  output mep_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mep_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mep_pkg::*;

  logic signed [OFFSET_W-1:0] offset_real;
  logic signed [OFFSET_W-1:0] offset_imag;
  logic [STEP_W-1:0]          step_size;
  logic [COUNT_W-1:0]         max_iterations;

  cmd_t  cmd;
  stat_t stat;

  // The register bank takes a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_real    <= OFFSET_REAL_RST;
      offset_imag    <= OFFSET_IMAG_RST;
      step_size      <= STEP_SIZE_RST;
      max_iterations <= MAX_ITER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_OFFSET_REAL: offset_real    <= $signed(cfg_data[OFFSET_W-1:0]);
        CFG_OFFSET_IMAG: offset_imag    <= $signed(cfg_data[OFFSET_W-1:0]);
        CFG_STEP_SIZE:   step_size      <= cfg_data[STEP_W-1:0];
        CFG_MAX_ITER:    max_iterations <= cfg_data[COUNT_W-1:0];
        default:         ;
      endcase
    end
  end

  mep_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mep_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .pixel          (pixel),
    .offset_real    (offset_real),
    .offset_imag    (offset_imag),
    .step_size      (step_size),
    .max_iterations (max_iterations),
    .done           (done),
    .result         (result)
  );

endmodule

// File: rtl/mep_checker.sv
// Port-level checks of the escape-time pixel, bound to the top level.
// Depends only on the top-level ports of mandelbrot_escape_pixel.
module mep_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_ready
);

  // A result is only shown once the sequencer is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // An accepted request keeps the block busy in the next cycle.
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // No result can follow a request in the very next cycle.
  a_req_no_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result right after request");

  // The result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  // The register bank never refuses a write.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("cfg_ready low");

endmodule

bind mandelbrot_escape_pixel mep_checker u_mep_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .cfg_ready (cfg_ready)
);
